/* rtl/htfd_pkg.sv */
// Shared types, constants and the CRC-8 step function for the frame decoder.
// Depends on nothing; the core, the checker and the converter use it.
`default_nettype none

package htfd_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CRC_ERR = 2'd1,
        STATUS_DIAG    = 2'd2
    } status_t;

    // Measurement phase: what the next good frame is taken as.
    typedef enum logic {
        KIND_TEMP = 1'b0,
        KIND_HUM  = 1'b1
    } kind_t;

    // Outcome of the frame check, passed from the checker to the top level.
    typedef struct packed {
        status_t status;
        logic    good;
    } check_t;

    // Frame format.
    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] STATUS_MASK = 8'hFC;
    localparam logic [7:0] DIAG_ZEROS  = 8'h00;
    localparam logic [7:0] DIAG_ONES   = 8'hFF;

    // Sensor commands.
    localparam logic [7:0] CMD_TEMP = 8'hF3;
    localparam logic [7:0] CMD_HUM  = 8'hF5;

    // Widths of the reading and of the reported values.
    localparam int RAW_W   = 16;
    localparam int VALUE_W = 15;

    // Conversion: value = floor(scale * raw / 65536) - offset, in hundredths.
    localparam logic [14:0] TEMP_SCALE = 15'd17572;
    localparam logic [13:0] HUM_SCALE  = 14'd12500;
    localparam logic signed [VALUE_W:0] TEMP_OFFSET = 16'sd4685;
    localparam logic signed [VALUE_W-1:0] HUM_OFFSET = 15'sd600;
    localparam logic signed [VALUE_W-1:0] HUM_MAX    = 15'sd10000;
    localparam logic signed [VALUE_W-1:0] HUM_NONE   = -15'sd100;
    localparam logic signed [VALUE_W-1:0] TEMP_RESET = 15'sd0;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (crc[7])
            begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

/* rtl/htfd_frame_if.sv */
// Request channel carrying one three-byte sensor reply.
// Depends on nothing.
`default_nettype none

interface htfd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_msb;
    logic [7:0] data_lsb;
    logic [7:0] check_byte;

    modport source (output valid, output data_msb, output data_lsb,
                    output check_byte, input ready);
    modport sink   (input valid, input data_msb, input data_lsb,
                    input check_byte, output ready);
endinterface

`default_nettype wire

/* rtl/htfd_result_if.sv */
// Request channel carrying one decoded result.
// Depends on nothing.
`default_nettype none

interface htfd_result_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic              measured_kind;
    logic signed [14:0] temp_centi;
    logic signed [14:0] humidity_centi;
    logic [7:0]        next_command;

    modport source (output valid, output status, output measured_kind,
                    output temp_centi, output humidity_centi,
                    output next_command, input ready);
    modport sink   (input valid, input status, input measured_kind,
                    input temp_centi, input humidity_centi,
                    input next_command, output ready);
endinterface

`default_nettype wire

/* rtl/humidity_temp_frame_decoder_core.sv */
// Top level of the humidity / temperature frame decoder.
// A frame passes through the input register and then the result register.
// Throughput: one frame per cycle while results are taken; check, multiplies and state update share one stage.
// Reset: asynchronous, active low; clears both pipeline stages, sets the phase to
// temperature, the stored temperature to 0 and the stored humidity to -1.00 %.
// Depends on htfd_pkg, htfd_frame_if, htfd_result_if, htfd_check, htfd_convert.
`default_nettype none

module humidity_temp_frame_decoder_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    htfd_frame_if.sink         frame,
    htfd_result_if.source      result
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] msb_reg;
    logic [7:0] lsb_reg;
    logic [7:0] chk_reg;

    // Result register and decoder state.
    logic                                   out_valid_reg;
    htfd_pkg::status_t                      status_reg;
    htfd_pkg::kind_t                        kind_reg;
    logic [7:0]                             command_reg;
    htfd_pkg::kind_t                        phase_reg;
    logic signed [htfd_pkg::VALUE_W-1:0]    temp_reg;
    logic signed [htfd_pkg::VALUE_W-1:0]    hum_reg;

    htfd_pkg::kind_t                        phase_next;
    logic signed [htfd_pkg::VALUE_W-1:0]    temp_next;
    logic signed [htfd_pkg::VALUE_W-1:0]    hum_next;

    htfd_pkg::check_t                       check;
    logic signed [htfd_pkg::VALUE_W-1:0]    temp_value;
    logic signed [htfd_pkg::VALUE_W-1:0]    hum_value;
    logic                                   advance;

    // Frame check and conversion on the registered request.
    htfd_check u_check (
        .data_msb   (msb_reg),
        .data_lsb   (lsb_reg),
        .check_byte (chk_reg),
        .check      (check)
    );

    htfd_convert u_convert (
        .data_msb   (msb_reg),
        .data_lsb   (lsb_reg),
        .temp_value (temp_value),
        .hum_value  (hum_value)
    );

    // A request moves into the result register when that register is free or
    // being emptied in the same cycle.
    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready = !in_valid_reg || advance;

    // State update for a good frame: store the value and flip the phase.
    always_comb
    begin
        phase_next = phase_reg;
        temp_next  = temp_reg;
        hum_next   = hum_reg;
        if (check.good)
        begin
            if (phase_reg == htfd_pkg::KIND_TEMP)
            begin
                temp_next  = temp_value;
                phase_next = htfd_pkg::KIND_HUM;
            end
            else
            begin
                hum_next   = hum_value;
                phase_next = htfd_pkg::KIND_TEMP;
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            in_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            msb_reg <= frame.data_msb;
            lsb_reg <= frame.data_lsb;
            chk_reg <= frame.check_byte;
        end
    end

    // Result register and stored readings.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= htfd_pkg::KIND_TEMP;
            temp_reg      <= htfd_pkg::TEMP_RESET;
            hum_reg       <= htfd_pkg::HUM_NONE;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                temp_reg      <= temp_next;
                hum_reg       <= hum_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= check.status;
            kind_reg    <= phase_reg;
            command_reg <= (phase_next == htfd_pkg::KIND_TEMP) ? htfd_pkg::CMD_TEMP
                                                               : htfd_pkg::CMD_HUM;
        end
    end

    // Result channel.
    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.measured_kind  = kind_reg;
    assign result.temp_centi     = temp_reg;
    assign result.humidity_centi = hum_reg;
    assign result.next_command   = command_reg;

    // A rejected frame leaves the phase alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !check.good |=> phase_reg == $past(phase_reg))
        else $error("phase changed on a rejected frame");

    // A good frame always flips the phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && check.good |=> phase_reg != $past(phase_reg))
        else $error("phase did not flip on a good frame");

    // While a result is valid, the reported command matches the current phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((command_reg == htfd_pkg::CMD_HUM)
                           == (phase_reg == htfd_pkg::KIND_HUM)))
        else $error("next command disagrees with phase");

    // Stored humidity is either the no-reading mark or within 0..100 %.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hum_reg == htfd_pkg::HUM_NONE)
        || ((hum_reg >= 15'sd0) && (hum_reg <= htfd_pkg::HUM_MAX)))
        else $error("stored humidity out of range");

    // With both stages full and the result stalled, no new request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !result.ready |-> !frame.ready)
        else $error("request taken while the pipeline is blocked");

endmodule

`default_nettype wire

/* rtl/htfd_check.sv */
// Frame checker: CRC-8 over the two data bytes and diagnostic pattern detection.
// Depends on htfd_pkg.
`default_nettype none

module htfd_check (
    input  wire logic [7:0]      data_msb,
    input  wire logic [7:0]      data_lsb,
    input  wire logic [7:0]      check_byte,
    output htfd_pkg::check_t     check
);

    logic [7:0] crc;
    logic       diag;

    // CRC over both data bytes, starting from zero.
    assign crc = htfd_pkg::crc8_byte(htfd_pkg::crc8_byte(8'h00, data_msb), data_lsb);

    // All-zero and all-ones readings are sensor diagnostics.
    assign diag = ((data_msb == htfd_pkg::DIAG_ZEROS) && (data_lsb == htfd_pkg::DIAG_ZEROS))
               || ((data_msb == htfd_pkg::DIAG_ONES) && (data_lsb == htfd_pkg::DIAG_ONES));

    // The CRC takes precedence over the diagnostic patterns.
    always_comb
    begin
        if (crc != check_byte)
        begin
            check.status = htfd_pkg::STATUS_CRC_ERR;
            check.good   = 1'b0;
        end
        else if (diag)
        begin
            check.status = htfd_pkg::STATUS_DIAG;
            check.good   = 1'b0;
        end
        else
        begin
            check.status = htfd_pkg::STATUS_OK;
            check.good   = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/htfd_convert.sv */
// Fixed-point conversion of the raw reading to temperature and to humidity.
// Depends on htfd_pkg.
`default_nettype none

module htfd_convert (
    input  wire logic [7:0]                          data_msb,
    input  wire logic [7:0]                          data_lsb,
    output logic signed [htfd_pkg::VALUE_W-1:0]      temp_value,
    output logic signed [htfd_pkg::VALUE_W-1:0]      hum_value
);

    logic [htfd_pkg::RAW_W-1:0] raw;
    logic [30:0]                temp_prod;
    logic [29:0]                hum_prod;
    logic signed [15:0]         temp_wide;
    logic signed [14:0]         hum_wide;

    // Reading with the two status bits cleared.
    assign raw = {data_msb, data_lsb & htfd_pkg::STATUS_MASK};

    // Scale by the constant and keep the integer part of the /65536.
    assign temp_prod = 31'(htfd_pkg::TEMP_SCALE) * 31'(raw);
    assign hum_prod  = 30'(htfd_pkg::HUM_SCALE) * 30'(raw);

    // Temperature: fits 15 bits signed after the offset.
    assign temp_wide  = signed'({1'b0, temp_prod[30:16]}) - htfd_pkg::TEMP_OFFSET;
    assign temp_value = temp_wide[14:0];

    // Humidity with offset, clamped to the physical range.
    assign hum_wide = signed'({1'b0, hum_prod[29:16]}) - htfd_pkg::HUM_OFFSET;

    always_comb
    begin
        if (hum_wide < 15'sd0)
        begin
            hum_value = 15'sd0;
        end
        else if (hum_wide > htfd_pkg::HUM_MAX)
        begin
            hum_value = htfd_pkg::HUM_MAX;
        end
        else
        begin
            hum_value = hum_wide;
        end
    end

endmodule

`default_nettype wire
